// File: hw/rtl/gbt_pkg.sv
// shared constants, codes and control structs of the glyph box tightener
`default_nettype none

package gbt_pkg;

    localparam int BUFFER_DEPTH_DEF = 4096;
    localparam int COORD_BITS_DEF   = 12;
    localparam int PAD_PIXELS_DEF   = 1;

    localparam int CHAN_W  = 8;
    localparam int LEVEL_W = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_ONES = '1;

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_BOTTOM = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_END   = 1'b1
    } opcode_t;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] thresh;
    } scan_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic tightened;
    } scan_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/gbt_ifs.sv
// request and result channels of the glyph box tightener
`default_nettype none

interface gbt_in_if;
    import gbt_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output opcode, output red, output green, output blue,
                    input ready);
    modport sink (input valid, input opcode, input red, input green, input blue,
                  output ready);
endinterface

interface gbt_out_if #(
    parameter int COORD_BITS = gbt_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_left;
    logic [COORD_BITS-1:0] out_top;
    logic [COORD_BITS:0]   out_right;
    logic [COORD_BITS:0]   out_bottom;
    logic                  tightened;

    modport source (output valid, output out_left, output out_top, output out_right,
                    output out_bottom, output tightened, input ready);
    modport sink (input valid, input out_left, input out_top, input out_right,
                  input out_bottom, input tightened, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gbt_store.sv
// brightness memory, one write port and one registered read port
`default_nettype none

module gbt_store #(
    parameter int DEPTH = gbt_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [gbt_pkg::LEVEL_W-1:0]  wr_data,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic      [gbt_pkg::LEVEL_W-1:0]  rd_data
);
    import gbt_pkg::*;

    logic [LEVEL_W-1:0] mem_array [DEPTH];
    logic [LEVEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gbt_scan.sv
// walk of the stored pixels, dark bounding box and padded result
`default_nettype none

module gbt_scan #(
    parameter int BUFFER_DEPTH = gbt_pkg::BUFFER_DEPTH_DEF,
    parameter int COORD_BITS   = gbt_pkg::COORD_BITS_DEF,
    parameter int PAD_PIXELS   = gbt_pkg::PAD_PIXELS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gbt_pkg::scan_cmd_t                  cmd,
    input  wire logic [$clog2(BUFFER_DEPTH+1)-1:0]   n,
    input  wire logic [COORD_BITS-1:0]               box_left,
    input  wire logic [COORD_BITS-1:0]               box_top,
    input  wire logic [COORD_BITS:0]                 box_right,
    input  wire logic [COORD_BITS:0]                 box_bottom,
    input  wire logic                                ack,
    output gbt_pkg::scan_stat_t                      stat,
    output logic      [COORD_BITS-1:0]               res_left,
    output logic      [COORD_BITS-1:0]               res_top,
    output logic      [COORD_BITS:0]                 res_right,
    output logic      [COORD_BITS:0]                 res_bottom,
    output logic                                     rd_en,
    output logic      [$clog2(BUFFER_DEPTH)-1:0]     rd_addr,
    input  wire logic [gbt_pkg::LEVEL_W-1:0]         rd_data
);
    import gbt_pkg::*;

    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int C      = COORD_BITS;
    localparam int W      = COORD_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [LEVEL_W-1:0] thresh_reg;
    logic [C-1:0]       col_reg;
    logic [C-1:0]       row_reg;
    logic               p_valid_reg;
    logic [C-1:0]       p_col_reg;
    logic [C-1:0]       p_row_reg;
    logic               found_reg;
    logic [C-1:0]       min_col_reg;
    logic [C-1:0]       max_col_reg;
    logic [C-1:0]       min_row_reg;
    logic [C-1:0]       max_row_reg;

    logic [W-1:0] box_width;
    logic         col_wrap;
    logic         hit;
    logic [W-1:0] lo_x;
    logic [W-1:0] lo_y;
    logic [W:0]   hi_x;
    logic [W:0]   hi_y;

    assign box_width = box_right - {1'b0, box_left};
    assign col_wrap  = (({1'b0, col_reg} + W'(1)) == box_width);
    assign hit       = p_valid_reg && (rd_data <= thresh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            n_reg       <= '0;
            idx_reg     <= '0;
            thresh_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            p_valid_reg <= 1'b0;
            p_col_reg   <= '0;
            p_row_reg   <= '0;
            found_reg   <= 1'b0;
            min_col_reg <= '1;
            max_col_reg <= '0;
            min_row_reg <= '1;
            max_row_reg <= '0;
        end
        else
        begin
            p_valid_reg <= (state_reg == S_WALK);
            p_col_reg   <= col_reg;
            p_row_reg   <= row_reg;

            if (hit)
            begin
                found_reg <= 1'b1;
                if (p_col_reg < min_col_reg)
                begin
                    min_col_reg <= p_col_reg;
                end
                if (p_col_reg > max_col_reg)
                begin
                    max_col_reg <= p_col_reg;
                end
                if (p_row_reg < min_row_reg)
                begin
                    min_row_reg <= p_row_reg;
                end
                if (p_row_reg > max_row_reg)
                begin
                    max_row_reg <= p_row_reg;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        n_reg       <= n;
                        thresh_reg  <= cmd.thresh;
                        idx_reg     <= '0;
                        col_reg     <= '0;
                        row_reg     <= '0;
                        found_reg   <= 1'b0;
                        min_col_reg <= '1;
                        max_col_reg <= '0;
                        min_row_reg <= '1;
                        max_row_reg <= '0;
                        state_reg   <= (n == '0) ? S_DONE : S_WALK;
                    end
                end
                S_WALK:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (col_wrap)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + C'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + C'(1);
                    end
                    if ((idx_reg + CNT_W'(1)) == n_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rd_en   = (state_reg == S_WALK);
    assign rd_addr = idx_reg[ADDR_W-1:0];

    // padded box in absolute coordinates, clamped to the box
    assign lo_x = {1'b0, box_left} + {1'b0, min_col_reg};
    assign lo_y = {1'b0, box_top} + {1'b0, min_row_reg};
    assign hi_x = {2'b00, box_left} + {2'b00, max_col_reg} + (W + 1)'(1 + PAD_PIXELS);
    assign hi_y = {2'b00, box_top} + {2'b00, max_row_reg} + (W + 1)'(1 + PAD_PIXELS);

    always_comb
    begin
        res_left   = box_left;
        res_top    = box_top;
        res_right  = box_right;
        res_bottom = box_bottom;
        if (found_reg)
        begin
            if (min_col_reg >= C'(PAD_PIXELS))
            begin
                res_left = lo_x[C-1:0] - C'(PAD_PIXELS);
            end
            if (min_row_reg >= C'(PAD_PIXELS))
            begin
                res_top = lo_y[C-1:0] - C'(PAD_PIXELS);
            end
            if (hi_x < {1'b0, box_right})
            begin
                res_right = hi_x[W-1:0];
            end
            if (hi_y < {1'b0, box_bottom})
            begin
                res_bottom = hi_y[W-1:0];
            end
        end
    end

    assign stat.busy      = (state_reg != S_IDLE);
    assign stat.done      = (state_reg == S_DONE);
    assign stat.tightened = found_reg;

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (idx_reg < n_reg))
        else $error("walk index beyond pixel count");

    a_found_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> ((min_col_reg <= max_col_reg) && (min_row_reg <= max_row_reg)))
        else $error("dark box bounds out of order");

    a_read_follows_walk: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> $past(state_reg == S_WALK))
        else $error("read data marked valid without a walk read");

endmodule

`default_nettype wire

// File: hw/rtl/glyph_box_tightener_unit.sv
// glyph box tightener top level: box registers, pixel intake, levels and result register
// pixel request: one pixel per cycle while in_ch.ready is high, no result
// end request: walk of the n stored pixels, drain and done states, then the result
// is registered once the output register is free; the walk reads one stored pixel
// per cycle from the memory read port, and no request is taken while it runs
// reset clears box registers, pixel count and levels; the brightness memory is not cleared
`default_nettype none

module glyph_box_tightener_unit #(
    parameter int BUFFER_DEPTH = gbt_pkg::BUFFER_DEPTH_DEF,
    parameter int COORD_BITS   = gbt_pkg::COORD_BITS_DEF,
    parameter int PAD_PIXELS   = gbt_pkg::PAD_PIXELS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire gbt_pkg::cfg_idx_t     cfg_index,
    input  wire logic [COORD_BITS:0]   cfg_data,
    gbt_in_if.sink                     in_ch,
    gbt_out_if.source                  out_ch
);
    import gbt_pkg::*;

    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int C      = COORD_BITS;
    localparam int W      = COORD_BITS + 1;
    localparam int AREA_W = 2 * W;
    localparam int CMP_W  = (AREA_W > CNT_W) ? AREA_W : CNT_W;

    logic [C-1:0]       left_reg;
    logic [C-1:0]       top_reg;
    logic [W-1:0]       right_reg;
    logic [W-1:0]       bottom_reg;
    logic [CNT_W-1:0]   pixel_count_reg;
    logic [LEVEL_W-1:0] darkest_reg;
    logic [LEVEL_W-1:0] brightest_reg;
    logic               out_valid_reg;
    logic [C-1:0]       out_left_reg;
    logic [C-1:0]       out_top_reg;
    logic [W-1:0]       out_right_reg;
    logic [W-1:0]       out_bottom_reg;
    logic               tightened_reg;

    logic               span_ok;
    logic [W-1:0]       span_w;
    logic [W-1:0]       span_h;
    logic [AREA_W-1:0]  area_prod;
    logic [CMP_W-1:0]   area_ext;
    logic [CMP_W-1:0]   count_ext;
    logic               room;
    logic               accept;
    logic               pix_take;
    logic               end_take;
    logic [LEVEL_W-1:0] brightness;
    logic [LEVEL_W:0]   level_sum;
    logic [CNT_W-1:0]   walk_n;
    logic               out_load;

    scan_cmd_t  cmd;
    scan_stat_t stat;

    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic [LEVEL_W-1:0] rd_data;
    logic [C-1:0]       res_left;
    logic [C-1:0]       res_top;
    logic [W-1:0]       res_right;
    logic [W-1:0]       res_bottom;

    // box area from the live registers
    assign span_ok   = (right_reg > {1'b0, left_reg}) && (bottom_reg > {1'b0, top_reg});
    assign span_w    = right_reg - {1'b0, left_reg};
    assign span_h    = bottom_reg - {1'b0, top_reg};
    assign area_prod = span_ok ? ({{W{1'b0}}, span_w} * {{W{1'b0}}, span_h}) : '0;
    assign area_ext  = CMP_W'(area_prod);
    assign count_ext = CMP_W'(pixel_count_reg);
    assign room      = (count_ext < area_ext) && (pixel_count_reg < CNT_W'(BUFFER_DEPTH));

    assign in_ch.ready = !stat.busy;
    assign accept      = in_ch.valid && in_ch.ready;
    assign pix_take    = accept && (in_ch.opcode == OP_PIXEL) && room;
    assign end_take    = accept && (in_ch.opcode == OP_END);

    assign brightness = {2'b00, in_ch.red} + {2'b00, in_ch.green} + {2'b00, in_ch.blue};
    assign level_sum  = {1'b0, darkest_reg} + {1'b0, brightest_reg};
    assign walk_n     = (count_ext > area_ext) ? CNT_W'(area_ext) : pixel_count_reg;

    assign cmd.start  = end_take;
    assign cmd.thresh = level_sum[LEVEL_W:1];

    assign out_load = stat.done && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg        <= '0;
            top_reg         <= '0;
            right_reg       <= '0;
            bottom_reg      <= '0;
            pixel_count_reg <= '0;
            darkest_reg     <= LEVEL_ONES;
            brightest_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEFT:   left_reg   <= cfg_data[C-1:0];
                    CFG_TOP:    top_reg    <= cfg_data[C-1:0];
                    CFG_RIGHT:  right_reg  <= cfg_data;
                    CFG_BOTTOM: bottom_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (end_take)
            begin
                pixel_count_reg <= '0;
                darkest_reg     <= LEVEL_ONES;
                brightest_reg   <= '0;
            end
            else if (pix_take)
            begin
                pixel_count_reg <= pixel_count_reg + CNT_W'(1);
                if (brightness < darkest_reg)
                begin
                    darkest_reg <= brightness;
                end
                if (brightness > brightest_reg)
                begin
                    brightest_reg <= brightness;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_left_reg   <= res_left;
            out_top_reg    <= res_top;
            out_right_reg  <= res_right;
            out_bottom_reg <= res_bottom;
            tightened_reg  <= stat.tightened;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_left   = out_left_reg;
    assign out_ch.out_top    = out_top_reg;
    assign out_ch.out_right  = out_right_reg;
    assign out_ch.out_bottom = out_bottom_reg;
    assign out_ch.tightened  = tightened_reg;

    gbt_store #(
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (pix_take),
        .wr_addr (pixel_count_reg[ADDR_W-1:0]),
        .wr_data (brightness),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbt_scan #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .COORD_BITS   (COORD_BITS),
        .PAD_PIXELS   (PAD_PIXELS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .n          (walk_n),
        .box_left   (left_reg),
        .box_top    (top_reg),
        .box_right  (right_reg),
        .box_bottom (bottom_reg),
        .ack        (out_load),
        .stat       (stat),
        .res_left   (res_left),
        .res_top    (res_top),
        .res_right  (res_right),
        .res_bottom (res_bottom),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        end_take |=> (pixel_count_reg == '0))
        else $error("pixel count not cleared by end request");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_count_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("pixel count beyond memory depth");

    a_levels_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_count_reg != '0) |-> (darkest_reg <= brightest_reg))
        else $error("darkest level above brightest level");

endmodule

`default_nettype wire

// File: tb/glyph_box_tightener_unit_tb.sv
// self-checking testbench of the glyph box tightener: random glyph images against a box predictor
module glyph_box_tightener_unit_tb;
    import gbt_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_WAIT       = 19;
    localparam int LONG_HOLD      = 1500;
    localparam int RANDOM_ITEMS   = 800;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int CW             = COORD_BITS_DEF;

    typedef struct packed {
        logic                is_reg;
        opcode_t             op;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        cfg_idx_t            idx;
        logic [CW:0]         data;
    } pending_req_t;

    typedef struct packed {
        logic [CW-1:0] left;
        logic [CW-1:0] top;
        logic [CW:0]   right;
        logic [CW:0]   bottom;
        logic          tightened;
    } glyph_box_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [CW:0] cfg_data;

    gbt_in_if in_ch();
    gbt_out_if #(.COORD_BITS(CW)) out_ch();

    glyph_box_tightener_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor state
    logic [CW-1:0]      box_l = '0;
    logic [CW-1:0]      box_t = '0;
    logic [CW:0]        box_r = '0;
    logic [CW:0]        box_b = '0;
    logic [LEVEL_W-1:0] level_store [BUFFER_DEPTH_DEF];
    int unsigned        taken_count = 0;
    logic [LEVEL_W-1:0] darkest = LEVEL_ONES;
    logic [LEVEL_W-1:0] brightest = '0;

    pending_req_t pending_reqs[$];
    glyph_box_t   expected_boxes[$];
    pending_req_t active_req;

    int unsigned ends_queued = 0;
    int unsigned random_items = 0;
    int unsigned pressure_mark = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;
    int unsigned settle_cnt = 0;
    int unsigned send_wait = 0;
    int unsigned send_burst = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_burst = 0;
    int unsigned hold_cnt = 0;
    logic        stim_done = 1'b0;

    function automatic longint unsigned box_area();
        if (box_r <= {1'b0, box_l} || box_b <= {1'b0, box_t})
            return 0;
        return longint'(box_r - {1'b0, box_l}) * longint'(box_b - {1'b0, box_t});
    endfunction

    function automatic void write_box_reg(cfg_idx_t idx, logic [CW:0] d);
        case (idx)
            CFG_LEFT:   box_l = d[CW-1:0];
            CFG_TOP:    box_t = d[CW-1:0];
            CFG_RIGHT:  box_r = d;
            CFG_BOTTOM: box_b = d;
            default:    ;
        endcase
    endfunction

    function automatic void take_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                       logic [CHAN_W-1:0] b);
        logic [LEVEL_W-1:0] lvl;
        lvl = LEVEL_W'(r) + LEVEL_W'(g) + LEVEL_W'(b);
        if (longint'(taken_count) < box_area() && taken_count < BUFFER_DEPTH_DEF) begin
            level_store[taken_count] = lvl;
            taken_count++;
            if (lvl < darkest)
                darkest = lvl;
            if (lvl > brightest)
                brightest = lvl;
        end
    endfunction

    function automatic glyph_box_t finish_box();
        longint unsigned area;
        int unsigned     n, i, width, thresh, x, y, er, eb;
        int unsigned     gx0, gy0, gx1, gy1, rl, rt, rr, rb;
        logic            found;
        glyph_box_t      res;
        rl = box_l;
        rt = box_t;
        rr = box_r;
        rb = box_b;
        found = 1'b0;
        res.tightened = 1'b0;
        area = box_area();
        n = (longint'(taken_count) < area) ? taken_count : 32'(area);
        if (n > 0) begin
            width = 32'(box_r) - 32'(box_l);
            thresh = (32'(darkest) + 32'(brightest)) / 2;
            gx0 = box_r;
            gy0 = box_b;
            gx1 = box_l;
            gy1 = box_t;
            for (i = 0; i < n; i++) begin
                if (32'(level_store[i]) <= thresh) begin
                    x = 32'(box_l) + i % width;
                    y = 32'(box_t) + i / width;
                    found = 1'b1;
                    if (x < gx0) gx0 = x;
                    if (y < gy0) gy0 = y;
                    if (x > gx1) gx1 = x;
                    if (y > gy1) gy1 = y;
                end
            end
            if (found && gx0 <= gx1 && gy0 <= gy1) begin
                er = gx1 + 1 + PAD_PIXELS_DEF;
                eb = gy1 + 1 + PAD_PIXELS_DEF;
                rl = (gx0 >= 32'(box_l) + PAD_PIXELS_DEF) ? gx0 - PAD_PIXELS_DEF : 32'(box_l);
                rt = (gy0 >= 32'(box_t) + PAD_PIXELS_DEF) ? gy0 - PAD_PIXELS_DEF : 32'(box_t);
                rr = (er < 32'(box_r)) ? er : 32'(box_r);
                rb = (eb < 32'(box_b)) ? eb : 32'(box_b);
                res.tightened = 1'b1;
            end
        end
        res.left = CW'(rl);
        res.top = CW'(rt);
        res.right = (CW + 1)'(rr);
        res.bottom = (CW + 1)'(rb);
        taken_count = 0;
        darkest = LEVEL_ONES;
        brightest = '0;
        return res;
    endfunction

    function automatic int unsigned draw_wait(ref int unsigned burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void push_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                       logic [CHAN_W-1:0] b);
        pending_req_t req;
        req = '0;
        req.op = OP_PIXEL;
        req.red = r;
        req.green = g;
        req.blue = b;
        pending_reqs.push_back(req);
    endfunction

    function automatic void push_end();
        pending_req_t req;
        req = '0;
        req.op = OP_END;
        req.red = CHAN_W'($urandom);
        req.green = CHAN_W'($urandom);
        req.blue = CHAN_W'($urandom);
        pending_reqs.push_back(req);
        ends_queued++;
    endfunction

    function automatic void push_reg(cfg_idx_t idx, logic [CW:0] d);
        pending_req_t req;
        req = '0;
        req.is_reg = 1'b1;
        req.idx = idx;
        req.data = d;
        pending_reqs.push_back(req);
    endfunction

    function automatic void push_bounds(int unsigned l, int unsigned t, int unsigned r,
                                        int unsigned b);
        push_reg(CFG_LEFT, {1'($urandom_range(0, 1)), CW'(l)});
        push_reg(CFG_TOP, {1'($urandom_range(0, 1)), CW'(t)});
        push_reg(CFG_RIGHT, (CW + 1)'(r));
        push_reg(CFG_BOTTOM, (CW + 1)'(b));
    endfunction

    // raster image: bright background, dark glyph rectangle, some noise; or all random, or one flat shade
    function automatic void queue_glyph_box(int unsigned w, int unsigned h, int unsigned npix);
        int unsigned       gx0, gx1, gy0, gy1, x, y, i, style;
        logic [CHAN_W-1:0] shade;
        gx0 = $urandom_range(0, w - 1);
        gx1 = $urandom_range(gx0, w - 1);
        gy0 = $urandom_range(0, h - 1);
        gy1 = $urandom_range(gy0, h - 1);
        style = $urandom_range(0, 9);
        shade = CHAN_W'($urandom);
        for (i = 0; i < npix; i++) begin
            x = i % w;
            y = i / w;
            if (style == 0 || $urandom_range(0, 15) == 0)
                push_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
            else if (style == 1)
                push_pixel(shade, shade, shade);
            else if (x >= gx0 && x <= gx1 && y >= gy0 && y <= gy1)
                push_pixel(CHAN_W'($urandom_range(0, 60)), CHAN_W'($urandom_range(0, 60)),
                           CHAN_W'($urandom_range(0, 60)));
            else
                push_pixel(CHAN_W'($urandom_range(180, 255)), CHAN_W'($urandom_range(180, 255)),
                           CHAN_W'($urandom_range(180, 255)));
        end
    endfunction

    function automatic void queue_random_phase();
        int unsigned kind, w, h, l, t, boxes, area, npix, sel, k;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            // inverted or zero-size box, every pixel dropped
            l = $urandom_range(1, 4095);
            t = $urandom_range(1, 4095);
            if ($urandom_range(0, 1) == 0)
                push_bounds(l, t, $urandom_range(0, l), t + $urandom_range(1, 8));
            else
                push_bounds(l, t, l + $urandom_range(0, 8), $urandom_range(0, t));
            repeat ($urandom_range(0, 3))
                push_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
            push_end();
            random_items++;
            return;
        end
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 8);
        l = $urandom_range(0, 4096 - w);
        t = $urandom_range(0, 4096 - h);
        if (kind == 1)
            l = 4096 - w;
        if (kind == 2)
            t = 4096 - h;
        if (kind == 3) begin
            l = 0;
            t = 0;
        end
        push_bounds(l, t, l + w, t + h);
        area = w * h;
        boxes = $urandom_range(1, 3);
        for (k = 0; k < boxes; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                npix = area;
            else if (sel < 17)
                npix = $urandom_range(0, area - 1);
            else
                npix = area + $urandom_range(1, 4);
            queue_glyph_box(w, h, npix);
            push_end();
            random_items += ((npix < area) ? npix : area) + 1;
        end
    endfunction

    // request driver and predictor update
    always @(posedge clk or negedge rst_n) begin
        pending_req_t reg_req;
        logic         next_valid;
        logic         next_we;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            cfg_we <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                if (active_req.op == OP_PIXEL)
                    take_pixel(active_req.red, active_req.green, active_req.blue);
                else
                    expected_boxes.push_back(finish_box());
            end
            if (in_ch.valid || expected_boxes.size() != 0)
                settle_cnt = 0;
            else if (settle_cnt < SETTLE_CYCLES)
                settle_cnt++;
            next_valid = in_ch.valid && !in_ch.ready;
            next_we = 1'b0;
            if (!next_valid) begin
                if (send_wait > 0)
                    send_wait--;
                else if (pending_reqs.size() != 0) begin
                    if (!pending_reqs[0].is_reg) begin
                        active_req = pending_reqs.pop_front();
                        next_valid = 1'b1;
                        in_ch.opcode <= active_req.op;
                        in_ch.red <= active_req.red;
                        in_ch.green <= active_req.green;
                        in_ch.blue <= active_req.blue;
                        send_wait = draw_wait(send_burst);
                    end else if (settle_cnt >= SETTLE_CYCLES) begin
                        reg_req = pending_reqs.pop_front();
                        write_box_reg(reg_req.idx, reg_req.data);
                        next_we = 1'b1;
                        cfg_index <= reg_req.idx;
                        cfg_data <= reg_req.data;
                    end
                end
            end
            in_ch.valid <= next_valid;
            cfg_we <= next_we;
            if (pending_reqs.size() == 0 && !next_valid && !next_we)
                stim_done = 1'b1;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n) begin
        glyph_box_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_boxes.size() == 0) begin
                    $error("result with nothing expected: left %0d top %0d right %0d bottom %0d",
                           out_ch.out_left, out_ch.out_top, out_ch.out_right, out_ch.out_bottom);
                    fail_count++;
                end else begin
                    want = expected_boxes.pop_front();
                    if (out_ch.out_left !== want.left) begin
                        $error("out_left: expected %0d, actual %0d", want.left, out_ch.out_left);
                        fail_count++;
                    end
                    if (out_ch.out_top !== want.top) begin
                        $error("out_top: expected %0d, actual %0d", want.top, out_ch.out_top);
                        fail_count++;
                    end
                    if (out_ch.out_right !== want.right) begin
                        $error("out_right: expected %0d, actual %0d", want.right,
                               out_ch.out_right);
                        fail_count++;
                    end
                    if (out_ch.out_bottom !== want.bottom) begin
                        $error("out_bottom: expected %0d, actual %0d", want.bottom,
                               out_ch.out_bottom);
                        fail_count++;
                    end
                    if (out_ch.tightened !== want.tightened) begin
                        $error("tightened: expected %0d, actual %0d", want.tightened,
                               out_ch.tightened);
                        fail_count++;
                    end
                end
                recv_wait = draw_wait(recv_burst);
                if (results_seen == pressure_mark)
                    hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned i;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LEFT;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_PIXEL;
        in_ch.red = '0;
        in_ch.green = '0;
        in_ch.blue = '0;
        out_ch.ready = 1'b0;

        // zero box straight out of reset
        push_end();
        // darkest and brightest levels, excess dark pixels dropped
        push_bounds(0, 0, 3, 2);
        push_pixel(8'hff, 8'hff, 8'hff);
        push_pixel(8'd200, 8'd210, 8'd220);
        push_pixel(8'd180, 8'd190, 8'd255);
        push_pixel(8'd250, 8'd240, 8'd230);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd240);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_end();
        // inverted and zero-width boxes
        push_bounds(10, 10, 5, 20);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd90, 8'd90, 8'd90);
        push_end();
        push_bounds(4095, 7, 4095, 9);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_end();
        // far corner, padding clamped on all sides
        push_bounds(4095, 4095, 4096, 4096);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_end();
        // short box, then end with no pixels
        push_bounds(100, 200, 104, 203);
        queue_glyph_box(4, 3, 5);
        push_end();
        push_end();
        // right edge moved while the box is half sent
        push_bounds(20, 30, 24, 34);
        queue_glyph_box(4, 4, 10);
        push_reg(CFG_RIGHT, 13'd22);
        push_end();

        // receiver holds off while several boxes queue up behind it
        push_bounds(500, 600, 503, 603);
        pressure_mark = ends_queued + 1;
        repeat (6) begin
            queue_glyph_box(3, 3, 9);
            push_end();
        end

        while (random_items < RANDOM_ITEMS)
            queue_random_phase();

        for (i = 0; i < RESET_CYCLES; i++)
            @(posedge clk);
        rst_n <= 1'b1;
        while (!stim_done)
            @(posedge clk);
        while (expected_boxes.size() != 0)
            @(posedge clk);
        for (i = 0; i < DRAIN_CYCLES; i++)
            @(posedge clk);
        if (fail_count == 0 && expected_boxes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

endmodule

// File: glyph_box_tightener_unit.f
hw/rtl/gbt_pkg.sv
hw/rtl/gbt_ifs.sv
hw/rtl/gbt_store.sv
hw/rtl/gbt_scan.sv
hw/rtl/glyph_box_tightener_unit.sv
tb/glyph_box_tightener_unit_tb.sv
